// ===== rtl/fpe_pkg.sv =====
package fpe_pkg;

   localparam int PLANES  = 6;
   localparam int COMPS   = 4;
   localparam int SUM_W   = 34;
   localparam int HALF_W  = 17;
   localparam int SQ_W    = 68;
   localparam int ROOT_W  = 36;
   localparam int REM_W   = 37;
   localparam int QUOT_W  = 32;
   localparam int COEF_W  = 32;

   localparam logic [2:0] LAST_PLANE  = 3'd5;
   localparam logic [1:0] LAST_COMP   = 2'd3;
   localparam logic [1:0] LAST_SQCOMP = 2'd2;
   localparam logic [1:0] LAST_PART   = 2'd2;
   localparam logic [1:0] PART_LOW    = 2'd0;
   localparam logic [1:0] PART_CROSS  = 2'd1;
   // one root bit per bit pair of the 68-bit sum
   localparam logic [5:0] ROOT_FIRST  = 6'd33;
   localparam logic [5:0] DIV_FIRST   = 6'd31;

   localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] NEG_MAX = 32'h8000_0000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ROOT,
      ST_DIV_LOAD,
      ST_DIV_RUN,
      ST_DIV_SAVE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic       store_wr;
      logic       sq_step;
      logic       sq_first;
      logic       root_init;
      logic       root_step;
      logic       root_first;
      logic       div_load;
      logic       div_step;
      logic       coef_save;
      logic       emit;
      logic [2:0] plane;
      logic [1:0] comp;
      logic [1:0] part;
   } cmd_type;

   typedef struct packed {
      logic s_zero;
   } status_type;

endpackage

// ===== rtl/fpe_ctrl.sv =====
module fpe_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                last_column,
   input  fpe_pkg::status_type status,
   output fpe_pkg::cmd_type    cmd,
   output logic                busy
);

   fpe_pkg::state_type state_ff, state_in;
   logic [2:0] plane_ff, plane_in;
   logic [1:0] comp_ff, comp_in;
   logic [1:0] part_ff, part_in;
   logic [5:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fpe_pkg::ST_IDLE;
         plane_ff <= '0;
         comp_ff  <= '0;
         part_ff  <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         plane_ff <= plane_in;
         comp_ff  <= comp_in;
         part_ff  <= part_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      plane_in = plane_ff;
      comp_in  = comp_ff;
      part_in  = part_ff;
      step_in  = step_ff;
      cmd      = '0;
      cmd.plane = plane_ff;
      cmd.comp  = comp_ff;
      cmd.part  = part_ff;
      busy     = (state_ff != fpe_pkg::ST_IDLE);
      case (state_ff)
         fpe_pkg::ST_IDLE: begin
            if (start) begin
               cmd.store_wr = 1'b1;
               if (last_column) begin
                  plane_in = '0;
                  comp_in  = '0;
                  part_in  = '0;
                  state_in = fpe_pkg::ST_SQUARE;
               end
            end
         end
         fpe_pkg::ST_SQUARE: begin
            cmd.sq_step  = 1'b1;
            cmd.sq_first = (comp_ff == '0) && (part_ff == '0);
            if (part_ff == fpe_pkg::LAST_PART) begin
               part_in = '0;
               if (comp_ff == fpe_pkg::LAST_SQCOMP) begin
                  cmd.root_init = 1'b1;
                  comp_in  = '0;
                  step_in  = fpe_pkg::ROOT_FIRST;
                  state_in = fpe_pkg::ST_ROOT;
               end else begin
                  comp_in = comp_ff + 2'd1;
               end
            end else begin
               part_in = part_ff + 2'd1;
            end
         end
         fpe_pkg::ST_ROOT: begin
            cmd.root_step  = 1'b1;
            cmd.root_first = (step_ff == fpe_pkg::ROOT_FIRST);
            if ((step_ff == fpe_pkg::ROOT_FIRST) && status.s_zero) begin
               state_in = fpe_pkg::ST_EMIT;
            end else if (step_ff == '0) begin
               comp_in  = '0;
               state_in = fpe_pkg::ST_DIV_LOAD;
            end else begin
               step_in = step_ff - 6'd1;
            end
         end
         fpe_pkg::ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            step_in  = fpe_pkg::DIV_FIRST;
            state_in = fpe_pkg::ST_DIV_RUN;
         end
         fpe_pkg::ST_DIV_RUN: begin
            cmd.div_step = 1'b1;
            if (step_ff == '0) begin
               state_in = fpe_pkg::ST_DIV_SAVE;
            end else begin
               step_in = step_ff - 6'd1;
            end
         end
         fpe_pkg::ST_DIV_SAVE: begin
            cmd.coef_save = 1'b1;
            if (comp_ff == fpe_pkg::LAST_COMP) begin
               state_in = fpe_pkg::ST_EMIT;
            end else begin
               comp_in  = comp_ff + 2'd1;
               state_in = fpe_pkg::ST_DIV_LOAD;
            end
         end
         fpe_pkg::ST_EMIT: begin
            cmd.emit = 1'b1;
            comp_in  = '0;
            part_in  = '0;
            if (plane_ff == fpe_pkg::LAST_PLANE) begin
               state_in = fpe_pkg::ST_IDLE;
            end else begin
               plane_in = plane_ff + 3'd1;
               state_in = fpe_pkg::ST_SQUARE;
            end
         end
         default: begin
            state_in = fpe_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/fpe_datapath.sv =====
module fpe_datapath #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  fpe_pkg::cmd_type     cmd,
   output fpe_pkg::status_type  status,
   input  logic [1:0]           column_index,
   input  logic signed [31:0]   row_zero,
   input  logic signed [31:0]   row_one,
   input  logic signed [31:0]   row_two,
   input  logic signed [31:0]   row_three,
   output logic [2:0]           plane_index,
   output logic signed [31:0]   normal_x,
   output logic signed [31:0]   normal_y,
   output logic signed [31:0]   normal_z,
   output logic signed [31:0]   plane_distance,
   output logic                 degenerate,
   output logic                 last_plane
);

   // numerator: |c| << FRAC_BITS plus half the root, one carry bit
   localparam int NUM_W = fpe_pkg::SUM_W + FRAC_BITS + 1;
   localparam int HI_W  = NUM_W - fpe_pkg::QUOT_W;

   logic signed [fpe_pkg::SUM_W-1:0] store_ff [fpe_pkg::PLANES][fpe_pkg::COMPS];
   logic [fpe_pkg::SQ_W-1:0]   acc_ff, acc_in;
   logic [fpe_pkg::ROOT_W-1:0] root_ff, root_in;
   logic [fpe_pkg::REM_W-1:0]  rem_ff, rem_in;
   logic [fpe_pkg::QUOT_W-1:0] quot_ff, quot_in;
   logic [fpe_pkg::QUOT_W-1:0] numlo_ff, numlo_in;
   logic                       neg_ff, neg_in;
   logic                       ovf_ff, ovf_in;
   logic                       degen_ff, degen_in;
   logic [fpe_pkg::COEF_W-1:0] coef_ff [fpe_pkg::COMPS];

   logic signed [fpe_pkg::SUM_W-1:0] sel;
   logic [fpe_pkg::SUM_W-1:0]        mag;
   logic [fpe_pkg::HALF_W-1:0]       mul_a, mul_b;
   logic [2*fpe_pkg::HALF_W-1:0]     prod;
   logic [fpe_pkg::SQ_W-1:0]         pp;
   logic [fpe_pkg::REM_W+1:0]        rrem, rtrial;
   logic [NUM_W-1:0]                 num;
   logic [HI_W-1:0]                  num_hi;
   logic [fpe_pkg::REM_W:0]          drem, ddiv;
   logic [fpe_pkg::COEF_W-1:0]       sat;

   always_ff @(posedge clock) begin
      if (cmd.store_wr) begin
         store_ff[0][column_index] <= 34'(row_three) + 34'(row_zero);
         store_ff[1][column_index] <= 34'(row_three) - 34'(row_zero);
         store_ff[2][column_index] <= 34'(row_three) + 34'(row_one);
         store_ff[3][column_index] <= 34'(row_three) - 34'(row_one);
         store_ff[4][column_index] <= 34'(row_three) + 34'(row_two);
         store_ff[5][column_index] <= 34'(row_three) - 34'(row_two);
      end
      if (cmd.coef_save) begin
         coef_ff[cmd.comp] <= sat;
      end
      acc_ff   <= acc_in;
      root_ff  <= root_in;
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
      numlo_ff <= numlo_in;
      neg_ff   <= neg_in;
      ovf_ff   <= ovf_in;
      degen_ff <= degen_in;
   end

   always_comb begin
      sel = store_ff[cmd.plane][cmd.comp];
      mag = sel[fpe_pkg::SUM_W-1] ? fpe_pkg::SUM_W'(-sel) : fpe_pkg::SUM_W'(sel);
      mul_a = mag[fpe_pkg::HALF_W-1:0];
      mul_b = mag[fpe_pkg::HALF_W-1:0];
      case (cmd.part)
         fpe_pkg::PART_LOW: begin
            mul_a = mag[fpe_pkg::HALF_W-1:0];
            mul_b = mag[fpe_pkg::HALF_W-1:0];
         end
         fpe_pkg::PART_CROSS: begin
            mul_a = mag[fpe_pkg::HALF_W-1:0];
            mul_b = mag[fpe_pkg::SUM_W-1:fpe_pkg::HALF_W];
         end
         default: begin
            mul_a = mag[fpe_pkg::SUM_W-1:fpe_pkg::HALF_W];
            mul_b = mag[fpe_pkg::SUM_W-1:fpe_pkg::HALF_W];
         end
      endcase
      prod = mul_a * mul_b;
      case (cmd.part)
         fpe_pkg::PART_LOW:   pp = fpe_pkg::SQ_W'(prod);
         fpe_pkg::PART_CROSS: pp = fpe_pkg::SQ_W'(prod) << (fpe_pkg::HALF_W + 1);
         default:             pp = fpe_pkg::SQ_W'(prod) << (2 * fpe_pkg::HALF_W);
      endcase

      status.s_zero = (acc_ff == '0);

      // one root bit per step from the top two bits of the sum
      rrem   = {rem_ff, acc_ff[fpe_pkg::SQ_W-1:fpe_pkg::SQ_W-2]};
      rtrial = {1'b0, root_ff, 2'b01};

      num    = (NUM_W'(mag) << FRAC_BITS) + NUM_W'(root_ff >> 1);
      num_hi = num[NUM_W-1:fpe_pkg::QUOT_W];

      drem = {rem_ff, numlo_ff[fpe_pkg::QUOT_W-1]};
      ddiv = (fpe_pkg::REM_W+1)'(root_ff);

      if (neg_ff) begin
         sat = (ovf_ff || quot_ff > fpe_pkg::NEG_MAX) ? fpe_pkg::NEG_MAX : -quot_ff;
      end else begin
         sat = (ovf_ff || quot_ff > fpe_pkg::POS_MAX) ? fpe_pkg::POS_MAX : quot_ff;
      end

      acc_in   = acc_ff;
      root_in  = root_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      numlo_in = numlo_ff;
      neg_in   = neg_ff;
      ovf_in   = ovf_ff;
      degen_in = degen_ff;

      if (cmd.sq_step) begin
         acc_in = (cmd.sq_first ? '0 : acc_ff) + pp;
      end
      if (cmd.root_init) begin
         root_in = '0;
         rem_in  = '0;
      end
      if (cmd.root_step) begin
         if (cmd.root_first) begin
            degen_in = status.s_zero;
         end
         acc_in = acc_ff << 2;
         if (rrem >= rtrial) begin
            rem_in  = fpe_pkg::REM_W'(rrem - rtrial);
            root_in = {root_ff[fpe_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = fpe_pkg::REM_W'(rrem);
            root_in = {root_ff[fpe_pkg::ROOT_W-2:0], 1'b0};
         end
      end
      if (cmd.div_load) begin
         neg_in   = sel[fpe_pkg::SUM_W-1];
         ovf_in   = (fpe_pkg::ROOT_W'(num_hi) >= root_ff);
         rem_in   = fpe_pkg::REM_W'(num_hi);
         numlo_in = num[fpe_pkg::QUOT_W-1:0];
         quot_in  = '0;
      end
      if (cmd.div_step) begin
         numlo_in = numlo_ff << 1;
         if (drem >= ddiv) begin
            rem_in  = fpe_pkg::REM_W'(drem - ddiv);
            quot_in = {quot_ff[fpe_pkg::QUOT_W-2:0], 1'b1};
         end else begin
            rem_in  = fpe_pkg::REM_W'(drem);
            quot_in = {quot_ff[fpe_pkg::QUOT_W-2:0], 1'b0};
         end
      end
   end

   assign plane_index    = cmd.plane;
   assign normal_x       = degen_ff ? '0 : coef_ff[0];
   assign normal_y       = degen_ff ? '0 : coef_ff[1];
   assign normal_z       = degen_ff ? '0 : coef_ff[2];
   assign plane_distance = degen_ff ? '0 : coef_ff[3];
   assign degenerate     = degen_ff;
   assign last_plane     = (cmd.plane == fpe_pkg::LAST_PLANE);

endmodule

// ===== rtl/frustum_plane_extract_top.sv =====
// A non-final column is stored when start is seen in idle, and busy stays low.
// A final column runs each plane through square, root, then load, divide and save per
// component, then emit; a degenerate plane goes from its first root step to emit.
// Throughput is set by the bit-serial root and divide unit shared by all planes.
// Results strobe on rsp_valid for one cycle each; the receiver cannot stall.
// Synchronous active-high reset returns the controller to idle; the store is not cleared.
module frustum_plane_extract_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_column_index,
   input  logic signed [31:0] req_row_zero,
   input  logic signed [31:0] req_row_one,
   input  logic signed [31:0] req_row_two,
   input  logic signed [31:0] req_row_three,
   input  logic               req_last_column,
   output logic               rsp_valid,
   output logic [2:0]         rsp_plane_index,
   output logic signed [31:0] rsp_normal_x,
   output logic signed [31:0] rsp_normal_y,
   output logic signed [31:0] rsp_normal_z,
   output logic signed [31:0] rsp_plane_distance,
   output logic               rsp_degenerate,
   output logic               rsp_last_plane
);

   fpe_pkg::cmd_type    cmd;
   fpe_pkg::status_type status;

   fpe_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .last_column (req_last_column),
      .status      (status),
      .cmd         (cmd),
      .busy        (busy)
   );

   fpe_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock          (clock),
      .cmd            (cmd),
      .status         (status),
      .column_index   (req_column_index),
      .row_zero       (req_row_zero),
      .row_one        (req_row_one),
      .row_two        (req_row_two),
      .row_three      (req_row_three),
      .plane_index    (rsp_plane_index),
      .normal_x       (rsp_normal_x),
      .normal_y       (rsp_normal_y),
      .normal_z       (rsp_normal_z),
      .plane_distance (rsp_plane_distance),
      .degenerate     (rsp_degenerate),
      .last_plane     (rsp_last_plane)
   );

   assign rsp_valid = cmd.emit;

endmodule

// ===== rtl/fpe_checker.sv =====
module fpe_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               req_last_column,
   input logic               rsp_valid,
   input logic signed [31:0] rsp_normal_x,
   input logic signed [31:0] rsp_plane_distance,
   input logic               rsp_degenerate,
   input logic               rsp_last_plane
);

   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result outside a busy period");

   a_column_only: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_last_column |=> !busy)
      else $error("non-final column left the block busy");

   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_plane |=> !busy)
      else $error("still busy after the far plane");

   a_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_plane |=> !rsp_valid)
      else $error("results back to back");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_normal_x == 0 && rsp_plane_distance == 0)
      else $error("degenerate plane not zero");

endmodule

bind frustum_plane_extract_top fpe_checker u_fpe_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .req_last_column    (req_last_column),
   .rsp_valid          (rsp_valid),
   .rsp_normal_x       (rsp_normal_x),
   .rsp_plane_distance (rsp_plane_distance),
   .rsp_degenerate     (rsp_degenerate),
   .rsp_last_plane     (rsp_last_plane)
);

// ===== tb/tb.sv =====
module tb;

   localparam int FRAC     = 16;
   localparam int CYC_MAX  = 1_000_000;
   localparam int N_RANDOM = 90;

   typedef struct {
      logic [2:0]         plane;
      logic signed [31:0] nx;
      logic signed [31:0] ny;
      logic signed [31:0] nz;
      logic signed [31:0] pdist;
      logic               degen;
      logic               last;
   } plane_type;

   class plane_scoreboard;
      logic signed [fpe_pkg::SUM_W-1:0] sums [fpe_pkg::PLANES*fpe_pkg::COMPS];
      plane_type planes_due [$];
      int     errors;

      function new();
         errors = 0;
         foreach (sums[i]) sums[i] = '0;
      endfunction

      function logic [35:0] root_floor(logic [71:0] s);
         logic [35:0] r;
         logic [71:0] c;
         r = '0;
         for (int b = 35; b >= 0; b--) begin
            c = {36'b0, r | (36'b1 << b)};
            if (c * c <= s) r = r | (36'b1 << b);
         end
         return r;
      endfunction

      function logic signed [31:0] scaled(logic signed [fpe_pkg::SUM_W-1:0] c,
                                          logic [35:0] r);
         logic [63:0] m;
         logic [63:0] q;
         m = c[fpe_pkg::SUM_W-1] ? 64'(-c) : 64'(c);
         m = m & ((64'b1 << fpe_pkg::SUM_W) - 1);
         q = ((m << FRAC) + {28'b0, r} / 2) / {28'b0, r};
         if (c[fpe_pkg::SUM_W-1]) begin
            if (q > 64'h8000_0000) q = 64'h8000_0000;
            return 32'(-q);
         end
         if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
         return q[31:0];
      endfunction

      // one accepted column transaction
      function void note_column(logic [1:0] col, logic signed [31:0] a0, a1, a2, a3,
                                logic fin);
         logic signed [fpe_pkg::SUM_W-1:0] w;
         logic [71:0] s;
         logic [35:0] r;
         logic [67:0] m;
         plane_type p;
         w = a3;
         sums[0*fpe_pkg::COMPS+col] = w + a0;
         sums[1*fpe_pkg::COMPS+col] = w - a0;
         sums[2*fpe_pkg::COMPS+col] = w + a1;
         sums[3*fpe_pkg::COMPS+col] = w - a1;
         sums[4*fpe_pkg::COMPS+col] = w + a2;
         sums[5*fpe_pkg::COMPS+col] = w - a2;
         if (!fin) return;
         for (int pl = 0; pl < fpe_pkg::PLANES; pl++) begin
            s = '0;
            for (int k = 0; k < 3; k++) begin
               m = sums[pl*fpe_pkg::COMPS+k][fpe_pkg::SUM_W-1]
                   ? 68'(-sums[pl*fpe_pkg::COMPS+k])
                   : 68'(sums[pl*fpe_pkg::COMPS+k]);
               m = m & ((68'b1 << fpe_pkg::SUM_W) - 1);
               s = s + 72'(m) * 72'(m);
            end
            p.plane = 3'(pl);
            p.last  = (pl == fpe_pkg::PLANES - 1);
            if (s == 0) begin
               p.nx = 0; p.ny = 0; p.nz = 0; p.pdist = 0; p.degen = 1'b1;
            end else begin
               r = root_floor(s);
               p.nx    = scaled(sums[pl*fpe_pkg::COMPS+0], r);
               p.ny    = scaled(sums[pl*fpe_pkg::COMPS+1], r);
               p.nz    = scaled(sums[pl*fpe_pkg::COMPS+2], r);
               p.pdist = scaled(sums[pl*fpe_pkg::COMPS+3], r);
               p.degen = 1'b0;
            end
            planes_due.insert(planes_due.size(), p);
         end
      endfunction

      function void check_plane(plane_type got);
         plane_type e;
         if (planes_due.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected plane %0d x=%h y=%h z=%h d=%h", got.plane, got.nx,
                        got.ny, got.nz, got.pdist);
            return;
         end
         e = planes_due.pop_front();
         if (got.plane !== e.plane || got.nx !== e.nx || got.ny !== e.ny ||
             got.nz !== e.nz || got.pdist !== e.pdist || got.degen !== e.degen ||
             got.last !== e.last) begin
            errors++;
            if (errors <= 10)
               $display({"plane mismatch exp p=%0d %h %h %h %h dg=%b l=%b",
                         " got p=%0d %h %h %h %h dg=%b l=%b"},
                        e.plane, e.nx, e.ny, e.nz, e.pdist, e.degen, e.last,
                        got.plane, got.nx, got.ny, got.nz, got.pdist, got.degen,
                        got.last);
         end
      endfunction
   endclass

   logic               clock, reset, start, busy;
   logic [1:0]         req_column_index;
   logic signed [31:0] req_row_zero, req_row_one, req_row_two, req_row_three;
   logic               req_last_column;
   logic               rsp_valid;
   logic [2:0]         rsp_plane_index;
   logic signed [31:0] rsp_normal_x, rsp_normal_y, rsp_normal_z, rsp_plane_distance;
   logic               rsp_degenerate, rsp_last_plane;

   plane_scoreboard sb = new();
   int  cycles;
   bit  no_gaps;

   frustum_plane_extract_top #(.FRAC_BITS(FRAC)) i_dut (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYC_MAX) begin
         $display("[frustum_plane_extract_top] ERROR");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid)
         sb.check_plane('{rsp_plane_index, rsp_normal_x, rsp_normal_y, rsp_normal_z,
                          rsp_plane_distance, rsp_degenerate, rsp_last_plane});

   task automatic send_column(logic [1:0] col, logic signed [31:0] a0, a1, a2, a3,
                              logic fin);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start            = 1'b1;
      req_column_index = col;
      req_row_zero     = a0;
      req_row_one      = a1;
      req_row_two      = a2;
      req_row_three    = a3;
      req_last_column  = fin;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      sb.note_column(col, a0, a1, a2, a3, fin);
      @(negedge clock);
   endtask

   function automatic logic signed [31:0] pick_elem();
      case ($urandom_range(0, 6))
         0: return $urandom();
         1: return 32'sh7FFF_FFFF;
         2: return 32'sh8000_0000;
         3: return 0;
         4: return $signed($urandom_range(0, 2 * 65536)) - 65536;
         5: return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
         default: return $urandom() >>> $urandom_range(0, 31);
      endcase
   endfunction

   task automatic send_matrix();
      logic [1:0] ord [4];
      logic signed [31:0] a0, a1, a2, a3;
      int dg, j, t;
      for (int i = 0; i < 4; i++) ord[i] = 2'(i);
      for (int i = 3; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = ord[i]; ord[i] = ord[j]; ord[j] = 2'(t);
      end
      // sometimes force one plane's normal to zero
      dg = $urandom_range(0, 14);
      for (int i = 0; i < 4; i++) begin
         a0 = pick_elem(); a1 = pick_elem(); a2 = pick_elem(); a3 = pick_elem();
         if (dg < 6 && ord[i] != fpe_pkg::LAST_COMP) begin
            case (dg / 2)
               0: a0 = (dg % 2) ? -a3 : a3;
               1: a1 = (dg % 2) ? -a3 : a3;
               default: a2 = (dg % 2) ? -a3 : a3;
            endcase
         end
         send_column(ord[i], a0, a1, a2, a3, i == 3);
      end
   endtask

   initial begin
      reset = 1'b1; start = 1'b0; cycles = 0; no_gaps = 1'b0;
      req_column_index = '0; req_row_zero = '0; req_row_one = '0;
      req_row_two = '0; req_row_three = '0; req_last_column = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // extremes everywhere
      send_column(0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
      send_column(1, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 0);
      send_column(2, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 0);
      send_column(3, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1);
      // all zero: every plane degenerate
      no_gaps = 1'b1;
      for (int c = 0; c < 4; c++) send_column(2'(c), 0, 0, 0, 0, c == 3);
      no_gaps = 1'b0;
      // identity in fixed point
      for (int c = 0; c < 4; c++)
         send_column(2'(c), c == 0 ? 65536 : 0, c == 1 ? 65536 : 0,
                     c == 2 ? 65536 : 0, c == 3 ? 65536 : 0, c == 3);
      // tiny normal, huge distance: saturates both ways
      send_column(0, 1, 0, 0, 0, 0);
      send_column(1, 0, 1, 0, 0, 0);
      send_column(2, 0, 0, 1, 0, 0);
      send_column(3, 32'sh4000_0000, 32'shC000_0000, 32'sh7FFF_0000, 0, 1);
      // rewrite one column, emit again without a full matrix
      send_column(1, 32'sh0001_8000, -32'sh0000_4000, 32'sh0000_0003, -32'sh0002_0000, 0);
      send_column(1, 32'sh0003_0000, 32'sh0000_1000, -32'sh0000_0001, 32'sh0001_0000, 1);

      for (int n = 0; n < N_RANDOM;) begin
         no_gaps = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 4) != 0) begin
            send_matrix();
            n += 4;
         end else begin
            // stray column, maybe an early final
            send_column(2'($urandom_range(0, 3)), pick_elem(), pick_elem(), pick_elem(),
                        pick_elem(), $urandom_range(0, 2) == 0);
            n++;
         end
      end
      start = 1'b0;
      wait (sb.planes_due.size() == 0);
      repeat (300) @(posedge clock);
      if (sb.errors == 0)
         $display("[frustum_plane_extract_top] OK");
      else
         $display("[frustum_plane_extract_top] ERROR");
      $finish;
   end
endmodule
